// File: rtl/core/cwt_pkg.sv
package cwt_pkg;

  // Geometry and field widths
  localparam int NUM_PADS       = 8;
  localparam int PAD_IDX_W      = $clog2(NUM_PADS);
  localparam int SUM_W          = 18;
  localparam int CFG_W          = 12;
  localparam int CFG_IDX_W      = 8;
  localparam int SMOOTHING      = 64;
  localparam int TH_W           = 20;
  localparam int POSITION_SCALE = 4;
  localparam int HALF_SCALE     = POSITION_SCALE / 2;
  localparam int POS_MAX        = POSITION_SCALE * (NUM_PADS - 1);
  localparam int POS_W          = 5;
  localparam int STEP_W         = 4;

  // Centroid divider: pos_sum / cnt, quotient fits POS_W bits
  localparam int POS_SUM_W = $clog2(POSITION_SCALE * NUM_PADS * (NUM_PADS - 1) / 2 + 1);
  localparam int CNT_W     = $clog2(NUM_PADS + 1);
  localparam int REM_W     = CNT_W + 1;
  localparam int DIV_CNT_W = $clog2(POS_W);
  localparam int D_W       = POS_W + 2;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] MAX_COUNT_RST = CFG_W'(1000);
  localparam logic [CFG_W-1:0] HYST_RST      = CFG_W'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_DIV,
    ST_DETENT,
    ST_DONE
  } cwt_state_t;

  typedef struct packed {
    logic signed [TH_W-1:0] th;
    logic                   touched;
  } pad_upd_t;

  // Per-read config value scaled to the accumulated domain
  function automatic logic signed [TH_W-1:0] scale_cfg(input logic [CFG_W-1:0] v);
    scale_cfg = signed'(TH_W'(v) * TH_W'(SMOOTHING));
  endfunction

endpackage

// File: rtl/core/cwt_scan_if.sv
interface cwt_scan_if import cwt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] pad_sum_0;
  logic [SUM_W-1:0] pad_sum_1;
  logic [SUM_W-1:0] pad_sum_2;
  logic [SUM_W-1:0] pad_sum_3;
  logic [SUM_W-1:0] pad_sum_4;
  logic [SUM_W-1:0] pad_sum_5;
  logic [SUM_W-1:0] pad_sum_6;
  logic [SUM_W-1:0] pad_sum_7;

  modport source (
    output valid, pad_sum_0, pad_sum_1, pad_sum_2, pad_sum_3,
           pad_sum_4, pad_sum_5, pad_sum_6, pad_sum_7,
    input  ready
  );

  modport sink (
    input  valid, pad_sum_0, pad_sum_1, pad_sum_2, pad_sum_3,
           pad_sum_4, pad_sum_5, pad_sum_6, pad_sum_7,
    output ready
  );
endinterface

// File: rtl/core/cwt_result_if.sv
interface cwt_result_if import cwt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [NUM_PADS-1:0]      pad_mask;
  logic                     held;
  logic                     touch_start;
  logic                     touch_end;
  logic                     clicked;
  logic [POS_W-1:0]         position;
  logic signed [STEP_W-1:0] step_delta;

  modport source (
    output valid, pad_mask, held, touch_start, touch_end, clicked, position, step_delta,
    input  ready
  );

  modport sink (
    input  valid, pad_mask, held, touch_start, touch_end, clicked, position, step_delta,
    output ready
  );
endinterface

// File: rtl/core/cwt_cfg_if.sv
interface cwt_cfg_if import cwt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// File: rtl/core/cap_wheel_touch_tracker.sv
// Channel  Dir  Handshake      Payload
// scan     in   valid/ready    pad_sum_0 .. pad_sum_7 (18b each)
// result   out  valid/ready    pad_mask, held, touch_start, touch_end, clicked,
//                              position, step_delta
// cfg      in   valid/ready    index (8b), data (12b); 0 = max_count, 1 = hysteresis
//
// Per item: accept, a pass over the pads through the shared threshold unit, a
// restoring divide for the centroid, the detent step, then the output load.
// scan.ready and cfg.ready are high only in idle; a held result only delays the
// output load of the next item. rst is synchronous, active high: thresholds load
// max_count*64, touch flags and tracking state clear, no clearing pass.
module cap_wheel_touch_tracker import cwt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  cwt_scan_if.sink     scan,
  cwt_result_if.source result,
  cwt_cfg_if.sink      cfg
);

  localparam logic signed [D_W-1:0] HALF_D = D_W'(HALF_SCALE);

  cwt_state_t state;
  cwt_state_t state_next;

  // Configuration; max_count only matters at the moment it is written
  logic [CFG_W-1:0] hysteresis;

  // Per-pad state
  logic signed [TH_W-1:0] thr [NUM_PADS];
  logic [NUM_PADS-1:0]    touched;

  // Tracking state
  logic             held_now;
  logic             held_before;
  logic [POS_W-1:0] anchor;
  logic             moved;

  // Per-item working registers
  logic [SUM_W-1:0]     sums [NUM_PADS];
  logic [PAD_IDX_W-1:0] pad_idx;
  logic [POS_SUM_W-1:0] pos_sum;
  logic [CNT_W-1:0]     cnt;
  logic [NUM_PADS-1:0]  mask;
  logic [CNT_W-1:0]     rem;
  logic [POS_W-1:0]     div_q;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [POS_W-1:0]     pos_r;
  logic signed [STEP_W-1:0] step_r;

  // Output register
  logic                     out_valid;
  logic [NUM_PADS-1:0]      out_mask;
  logic                     out_held;
  logic                     out_start;
  logic                     out_end;
  logic                     out_clicked;
  logic [POS_W-1:0]         out_pos;
  logic signed [STEP_W-1:0] out_step;

  logic scan_acc;
  logic cfg_acc;
  logic out_load;
  logic last_pad;
  logic div_last;

  // ---------------------------------------------------------------------------
  // Shared threshold unit, walked over the pads one per cycle
  // ---------------------------------------------------------------------------
  pad_upd_t upd;

  cwt_pad_unit u_pad (
    .rd      (sums[pad_idx]),
    .th      (thr[pad_idx]),
    .touched (touched[pad_idx]),
    .hyst    (scale_cfg(hysteresis)),
    .upd     (upd)
  );

  logic [POS_SUM_W-1:0] pos_sum_next;
  logic [CNT_W-1:0]     cnt_next;

  always_comb begin
    pos_sum_next = pos_sum;
    cnt_next     = cnt;
    if (upd.touched) begin
      pos_sum_next = pos_sum + POS_SUM_W'(pad_idx) * POS_SUM_W'(POSITION_SCALE);
      cnt_next     = cnt + CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Centroid divide step: one quotient bit per cycle
  // ---------------------------------------------------------------------------
  logic [REM_W-1:0] trial;
  logic             q_bit;

  assign trial = {rem, div_q[POS_W-1]};
  assign q_bit = (trial >= REM_W'(cnt));

  // ---------------------------------------------------------------------------
  // Detent step
  // ---------------------------------------------------------------------------
  logic                     held_cur;
  logic [POS_W-1:0]         pos_cur;
  logic [POS_W-1:0]         anchor_base;
  logic signed [D_W-1:0]    d;
  logic signed [D_W-1:0]    e;
  logic signed [D_W-1:0]    mag;
  logic signed [D_W-1:0]    qv;
  logic signed [STEP_W-1:0] step_cur;
  logic signed [D_W-1:0]    anchor_sum;

  always_comb begin
    held_cur    = (cnt != '0);
    pos_cur     = held_cur ? div_q : '0;
    // first scan of a touch re-anchors at the current position
    anchor_base = held_before ? anchor : pos_cur;
    d           = signed'(D_W'(pos_cur)) - signed'(D_W'(anchor_base));
    e           = (d > 0) ? d - HALF_D : d + HALF_D;
    mag         = (e < 0) ? -e : e;
    qv          = D_W'(mag / POSITION_SCALE);
    step_cur    = held_cur ? STEP_W'((e < 0) ? -qv : qv) : '0;
    anchor_sum  = signed'(D_W'(anchor_base)) + D_W'(step_cur * POSITION_SCALE);
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign scan_acc = scan.valid && scan.ready;
  assign cfg_acc  = cfg.valid && cfg.ready;
  assign last_pad = (pad_idx == PAD_IDX_W'(NUM_PADS - 1));
  assign div_last = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    scan.ready = 1'b0;
    cfg.ready  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        scan.ready = 1'b1;
        cfg.ready  = 1'b1;
        if (scan.valid) begin
          state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (last_pad) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_DETENT;
        end
      end
      ST_DETENT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Config and per-pad state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      hysteresis <= HYST_RST;
      touched    <= '0;
      for (int i = 0; i < NUM_PADS; i++) begin
        thr[i] <= scale_cfg(MAX_COUNT_RST);
      end
    end else begin
      if (cfg_acc) begin
        case (cfg.index)
          REG_MAX_COUNT: begin
            // reload every threshold, keep touch flags
            for (int i = 0; i < NUM_PADS; i++) begin
              thr[i] <= scale_cfg(cfg.data);
            end
          end
          REG_HYSTERESIS: begin
            hysteresis <= cfg.data;
          end
          default: begin
          end
        endcase
      end
      if (state == ST_PAD) begin
        thr[pad_idx]     <= upd.th;
        touched[pad_idx] <= upd.touched;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tracking state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      held_now    <= 1'b0;
      held_before <= 1'b0;
      anchor      <= '0;
      moved       <= 1'b0;
    end else begin
      if (scan_acc) begin
        held_before <= held_now;
      end
      if (state == ST_DETENT) begin
        held_now <= held_cur;
        if (held_cur) begin
          anchor <= anchor_sum[POS_W-1:0];
          moved  <= (held_before && moved) || (step_cur != '0);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Working registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (scan_acc) begin
      sums[0] <= scan.pad_sum_0;
      sums[1] <= scan.pad_sum_1;
      sums[2] <= scan.pad_sum_2;
      sums[3] <= scan.pad_sum_3;
      sums[4] <= scan.pad_sum_4;
      sums[5] <= scan.pad_sum_5;
      sums[6] <= scan.pad_sum_6;
      sums[7] <= scan.pad_sum_7;
      pad_idx <= '0;
      pos_sum <= '0;
      cnt     <= '0;
      mask    <= '0;
    end
    case (state)
      ST_PAD: begin
        pos_sum       <= pos_sum_next;
        cnt           <= cnt_next;
        mask[pad_idx] <= upd.touched;
        pad_idx       <= pad_idx + PAD_IDX_W'(1);
        if (last_pad) begin
          // top bits of the dividend are below cnt whenever a pad is touched
          rem     <= CNT_W'(pos_sum_next[POS_SUM_W-1:POS_W]);
          div_q   <= pos_sum_next[POS_W-1:0];
          div_cnt <= DIV_CNT_W'(POS_W - 1);
        end
      end
      ST_DIV: begin
        rem     <= q_bit ? CNT_W'(trial - REM_W'(cnt)) : trial[CNT_W-1:0];
        div_q   <= {div_q[POS_W-2:0], q_bit};
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
      ST_DETENT: begin
        pos_r  <= pos_cur;
        step_r <= step_cur;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mask    <= mask;
      out_held    <= held_now;
      out_start   <= held_now && !held_before;
      out_end     <= !held_now && held_before;
      out_clicked <= !held_now && held_before && !moved;
      out_pos     <= pos_r;
      out_step    <= step_r;
    end
  end

  assign result.valid       = out_valid;
  assign result.pad_mask    = out_mask;
  assign result.held        = out_held;
  assign result.touch_start = out_start;
  assign result.touch_end   = out_end;
  assign result.clicked     = out_clicked;
  assign result.position    = out_pos;
  assign result.step_delta  = out_step;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DETENT && cnt != '0) |-> (rem < cnt))
    else $error("centroid remainder not below pad count");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_pos <= POS_W'(POS_MAX)))
    else $error("position beyond last pad");

  a_held_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_held == (out_mask != '0)))
    else $error("held does not match pad mask");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_held) |-> (out_pos == '0 && out_step == '0))
    else $error("nonzero position or step with no touch");

  a_start_no_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_start) |-> (out_step == '0 && !out_end))
    else $error("detent step on first scan of a touch");
`endif

endmodule

// File: rtl/core/cwt_pad_unit.sv
// Threshold/hysteresis update for one pad; shared across all pads.
module cwt_pad_unit import cwt_pkg::*; (
  input  logic [SUM_W-1:0]       rd,
  input  logic signed [TH_W-1:0] th,
  input  logic                   touched,
  input  logic signed [TH_W-1:0] hyst,
  output pad_upd_t               upd
);

  logic signed [TH_W-1:0] rd_s;
  logic signed [TH_W-1:0] up;
  logic signed [TH_W-1:0] dn;

  assign rd_s = signed'(TH_W'(rd));
  assign up   = rd_s + hyst;
  assign dn   = rd_s - hyst;

  always_comb begin
    upd.th      = th;
    upd.touched = touched;
    if (touched) begin
      if (rd_s < th) begin
        upd.touched = 1'b0;
        upd.th      = up;
      end else if (th < dn) begin
        upd.th = dn;
      end
    end else begin
      if (rd_s > th) begin
        upd.touched = 1'b1;
        upd.th      = dn;
      end else if (th > up) begin
        upd.th = up;
      end
    end
  end

endmodule
